// ===== hw/rtl/kti_pkg.sv =====
// shared types, constants and microcode table of the keyframe track interpolator
package kti_pkg;

    localparam int MAX_KEYS  = 64;
    localparam int IDX_W     = $clog2(MAX_KEYS);
    localparam int KEY_CNT_W = 7;
    localparam int SLOT_W    = 6;
    localparam int FRAME_W   = 24;
    localparam int VALUE_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int CNT_W     = $clog2(FRAC_W);
    localparam int PC_W      = 5;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // register map, byte addresses
    localparam logic [ADDR_W-1:0] REG_KEY_COUNT     = 3'd0;
    localparam logic [ADDR_W-1:0] REG_DEFAULT_VALUE = 3'd4;

    // 0.788 in signed Q2.16
    localparam logic signed [17:0] SCALE_Q16 = 18'sd51642;
    localparam logic signed [49:0] ROUND_HALF = 50'sd32768;
    localparam logic signed [33:0] SAT_HI = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] SAT_LO = 34'sh3_8000_0000;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_INIT,
        OP_LOAD_LO,
        OP_RD_NEXT,
        OP_CMP,
        OP_NOP,
        OP_CLAMP,
        OP_LOAD_VAL,
        OP_LOAD_DEF,
        OP_DIV,
        OP_RD_V0,
        OP_LOAD_V0,
        OP_DIFF,
        OP_MUL,
        OP_BLEND,
        OP_SCALE,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_QUERY,
        C_EMPTY,
        C_LAST,
        C_HIT,
        C_MORE,
        C_DIV_BUSY,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic no_query;
        logic empty;
        logic last;
        logic hit;
        logic div_busy;
        logic out_free;
    } status_t;

    localparam logic [PC_W-1:0] STEP_IDLE    = 5'd0;
    localparam logic [PC_W-1:0] STEP_INIT    = 5'd1;
    localparam logic [PC_W-1:0] STEP_LOAD_LO = 5'd2;
    localparam logic [PC_W-1:0] STEP_RD_NEXT = 5'd3;
    localparam logic [PC_W-1:0] STEP_CMP     = 5'd4;
    localparam logic [PC_W-1:0] STEP_LOOP    = 5'd5;
    localparam logic [PC_W-1:0] STEP_CLAMP   = 5'd6;
    localparam logic [PC_W-1:0] STEP_LD_VAL  = 5'd7;
    localparam logic [PC_W-1:0] STEP_DEFAULT = 5'd8;
    localparam logic [PC_W-1:0] STEP_DIV     = 5'd9;
    localparam logic [PC_W-1:0] STEP_RD_V0   = 5'd10;
    localparam logic [PC_W-1:0] STEP_LOAD_V0 = 5'd11;
    localparam logic [PC_W-1:0] STEP_DIFF    = 5'd12;
    localparam logic [PC_W-1:0] STEP_MUL     = 5'd13;
    localparam logic [PC_W-1:0] STEP_BLEND   = 5'd14;
    localparam logic [PC_W-1:0] STEP_SCALE   = 5'd15;
    localparam logic [PC_W-1:0] STEP_EMIT    = 5'd16;
    localparam logic [PC_W-1:0] STEP_RETRY   = 5'd17;

    // control store: a taken condition jumps to target, otherwise fall through
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            STEP_IDLE:    w = '{OP_IDLE,     C_NO_QUERY, STEP_IDLE};
            STEP_INIT:    w = '{OP_INIT,     C_EMPTY,    STEP_DEFAULT};
            STEP_LOAD_LO: w = '{OP_LOAD_LO,  C_LAST,     STEP_CLAMP};
            STEP_RD_NEXT: w = '{OP_RD_NEXT,  C_NEXT,     STEP_IDLE};
            STEP_CMP:     w = '{OP_CMP,      C_HIT,      STEP_DIV};
            STEP_LOOP:    w = '{OP_NOP,      C_MORE,     STEP_RD_NEXT};
            STEP_CLAMP:   w = '{OP_CLAMP,    C_NEXT,     STEP_IDLE};
            STEP_LD_VAL:  w = '{OP_LOAD_VAL, C_ALWAYS,   STEP_SCALE};
            STEP_DEFAULT: w = '{OP_LOAD_DEF, C_ALWAYS,   STEP_SCALE};
            STEP_DIV:     w = '{OP_DIV,      C_DIV_BUSY, STEP_DIV};
            STEP_RD_V0:   w = '{OP_RD_V0,    C_NEXT,     STEP_IDLE};
            STEP_LOAD_V0: w = '{OP_LOAD_V0,  C_NEXT,     STEP_IDLE};
            STEP_DIFF:    w = '{OP_DIFF,     C_NEXT,     STEP_IDLE};
            STEP_MUL:     w = '{OP_MUL,      C_NEXT,     STEP_IDLE};
            STEP_BLEND:   w = '{OP_BLEND,    C_NEXT,     STEP_IDLE};
            STEP_SCALE:   w = '{OP_SCALE,    C_NEXT,     STEP_IDLE};
            STEP_EMIT:    w = '{OP_EMIT,     C_OUT_FREE, STEP_IDLE};
            STEP_RETRY:   w = '{OP_NOP,      C_ALWAYS,   STEP_EMIT};
            default:      w = '{OP_NOP,      C_ALWAYS,   STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/kti_item_if.sv =====
// input channel: keyframe writes and time queries
interface kti_item_if import kti_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [SLOT_W-1:0]         key_slot;
    logic [FRAME_W-1:0]        key_frame;
    logic signed [VALUE_W-1:0] key_value;
    logic [FRAME_W-1:0]        query_time;

    modport source (output valid, command, key_slot, key_frame, key_value, query_time,
                    input ready);
    modport sink (input valid, command, key_slot, key_frame, key_value, query_time,
                  output ready);
endinterface

// ===== hw/rtl/kti_sample_if.sv =====
// result channel: one sampled value per query
interface kti_sample_if import kti_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] sample_value;
    logic [SLOT_W-1:0]         left_key;
    logic                      bracketed;
    logic                      track_present;

    modport source (output valid, sample_value, left_key, bracketed, track_present,
                    input ready);
    modport sink (input valid, sample_value, left_key, bracketed, track_present,
                  output ready);
endinterface

// ===== hw/rtl/keyframe_track_interpolator_core.sv =====
// top level: configuration registers, microcode sequencer and datapath
//
// item channel: command 0 stores key_frame/key_value into key_slot, command 1
// samples the track at query_time. a write beat gives no result and leaves the
// block idle. a query beat gives exactly one beat on the sample channel.
// apb port: key_count at byte 0, default_value at byte 4, pready always high;
// write them only while the block is idle.
// a query runs through the microprogram: the key search reads one frame from the
// key memory per pair, passing the read, compare and loop steps for each pair
// scanned; a hit then runs the bit-serial divider and the blend and scale steps,
// a miss the clamp, value load and scale steps, and an empty track loads the
// default and scales it. one query is worked on at a time; item.ready is high only
// in the idle step. the result register frees the sequencer to take the next
// item while a sample beat waits; if the receiver still stalls when the next
// result is ready, the sequencer waits at its emit step.
// reset clears key_count and default_value; key memory contents stay undefined
// until written.
module keyframe_track_interpolator_core import kti_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    kti_item_if.sink          item,
    kti_sample_if.source      sample,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [KEY_CNT_W-1:0]      key_count_reg;
    logic signed [VALUE_W-1:0] default_value_reg;
    logic                      cfg_wr;
    status_t                   status;
    op_t                       op;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg     <= '0;
            default_value_reg <= '0;
        end
        else if (cfg_wr)
        begin
            // word decode, low address bits ignored
            if (paddr[2] == REG_DEFAULT_VALUE[2])
                default_value_reg <= pwdata;
            else
                key_count_reg <= pwdata[KEY_CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_DEFAULT_VALUE[2]) ? default_value_reg
                  : DATA_W'(key_count_reg);

    kti_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .op     (op)
    );

    kti_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .key_count     (key_count_reg),
        .default_value (default_value_reg),
        .item          (item),
        .sample        (sample),
        .status        (status)
    );

    // an empty track reports neither a bracket nor a key index
    assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid |-> (sample.track_present ||
                          (!sample.bracketed && sample.left_key == '0)))
        else $error("empty-track result carries key information");

    // a query beat keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.command == CMD_QUERY) |=> !item.ready)
        else $error("item taken again right after a query beat");

    // a key_count write lands in the register
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && paddr[2] == REG_KEY_COUNT[2]) |=>
            key_count_reg == $past(pwdata[KEY_CNT_W-1:0]))
        else $error("key_count write lost");

endmodule

// ===== hw/rtl/kti_sequencer.sv =====
// microprogram counter with conditional jumps over the control store
module kti_sequencer import kti_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output op_t     op
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ucode_t          uword;
    logic            taken;

    assign uword = ucode_rom(pc_reg);
    assign op    = uword.op;

    always_comb
    begin
        unique case (uword.cond)
            C_NEXT:     taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_NO_QUERY: taken = status.no_query;
            C_EMPTY:    taken = status.empty;
            C_LAST:     taken = status.last;
            C_HIT:      taken = status.hit;
            C_MORE:     taken = !status.last;
            C_DIV_BUSY: taken = status.div_busy;
            C_OUT_FREE: taken = status.out_free;
            default:    taken = 1'b0;
        endcase
        pc_next = taken ? uword.target : PC_W'(pc_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= STEP_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule

// ===== hw/rtl/kti_datapath.sv =====
// key memories, search compare, bit-serial divider, blend and scale units, result register
module kti_datapath import kti_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  op_t                       op,
    input  logic [KEY_CNT_W-1:0]      key_count,
    input  logic signed [VALUE_W-1:0] default_value,
    kti_item_if.sink                  item,
    kti_sample_if.source              sample,
    output status_t                   status
);

    logic [FRAME_W-1:0]        frame_mem [MAX_KEYS];
    logic [VALUE_W-1:0]        value_mem [MAX_KEYS];
    logic [FRAME_W-1:0]        frame_rd_reg;
    logic signed [VALUE_W-1:0] value_rd_reg;
    logic [IDX_W-1:0]          frame_raddr;
    logic [IDX_W-1:0]          value_raddr;

    logic [FRAME_W-1:0]        t_reg;
    logic [KEY_CNT_W-1:0]      n_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [FRAME_W-1:0]        f_lo_reg;
    logic [FRAME_W-1:0]        rem_reg;
    logic [FRAME_W-1:0]        den_reg;
    logic [FRAC_W-1:0]         q_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [VALUE_W-1:0] v0_reg;
    logic signed [VALUE_W:0]   diff_reg;
    logic signed [49:0]        prod_reg;
    logic signed [VALUE_W-1:0] acc_reg;
    logic signed [48:0]        sprod_reg;
    logic [IDX_W-1:0]          left_reg;
    logic                      hit_reg;
    logic                      present_reg;

    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic [SLOT_W-1:0]         out_left_reg;
    logic                      out_hit_reg;
    logic                      out_present_reg;

    logic                      accept;
    logic                      wr_en;
    logic                      query_go;
    logic [KEY_CNT_W-1:0]      n_clip;
    logic [IDX_W-1:0]          idx_inc;
    logic                      pair_hit;
    logic                      out_free;
    logic [FRAME_W:0]          rem_shl;
    logic                      div_bit;
    logic [FRAME_W-1:0]        rem_next;
    logic signed [49:0]        prod_next;
    logic signed [33:0]        blend_sum;
    logic signed [48:0]        sprod_next;
    logic signed [49:0]        rounded;
    logic signed [33:0]        scaled;
    logic signed [VALUE_W-1:0] sat_value;

    assign item.ready = (op == OP_IDLE);
    assign accept     = item.valid && item.ready;
    assign wr_en      = accept && (item.command == CMD_WRITE);
    assign query_go   = accept && (item.command == CMD_QUERY);
    assign n_clip     = (key_count > KEY_CNT_W'(MAX_KEYS)) ? KEY_CNT_W'(MAX_KEYS) : key_count;
    assign idx_inc    = IDX_W'(idx_reg + 1'b1);
    assign pair_hit   = (f_lo_reg <= t_reg) && (t_reg < frame_rd_reg);
    assign out_free   = !out_valid_reg || sample.ready;

    assign frame_raddr = (op == OP_INIT) ? '0 : idx_inc;
    assign value_raddr = (op == OP_LOAD_V0) ? idx_inc : idx_reg;

    assign status.no_query = !query_go;
    assign status.empty    = (n_reg == '0);
    assign status.last     = (KEY_CNT_W'(idx_reg) + KEY_CNT_W'(1)) >= n_reg;
    assign status.hit      = pair_hit;
    assign status.div_busy = (cnt_reg != '1);
    assign status.out_free = out_free;

    // restoring division, remainder stays below the divisor
    assign rem_shl  = {rem_reg, 1'b0};
    assign div_bit  = (rem_shl >= {1'b0, den_reg});
    assign rem_next = div_bit ? FRAME_W'(rem_shl - {1'b0, den_reg}) : rem_shl[FRAME_W-1:0];

    assign prod_next  = diff_reg * $signed({1'b0, q_reg});
    assign blend_sum  = $signed({{2{v0_reg[VALUE_W-1]}}, v0_reg}) + $signed(prod_reg[49:16]);
    assign sprod_next = acc_reg * SCALE_Q16;
    assign rounded    = sprod_reg + ROUND_HALF;
    assign scaled     = $signed(rounded[49:16]);

    always_comb
    begin
        priority if (scaled > SAT_HI)
            sat_value = SAT_HI[VALUE_W-1:0];
        else if (scaled < SAT_LO)
            sat_value = SAT_LO[VALUE_W-1:0];
        else
            sat_value = scaled[VALUE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            frame_mem[item.key_slot[IDX_W-1:0]] <= item.key_frame;
        frame_rd_reg <= frame_mem[frame_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            value_mem[item.key_slot[IDX_W-1:0]] <= item.key_value;
        value_rd_reg <= value_mem[value_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (op)
                OP_IDLE:
                begin
                    if (query_go)
                        n_reg <= n_clip;
                end
                OP_INIT:
                    idx_reg <= '0;
                OP_CMP:
                begin
                    if (pair_hit)
                        cnt_reg <= '0;
                    else
                        idx_reg <= idx_inc;
                end
                OP_DIV:
                    cnt_reg <= CNT_W'(cnt_reg + 1'b1);
                default:
                begin
                end
            endcase
            if (op == OP_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (sample.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_IDLE:
            begin
                if (query_go)
                    t_reg <= item.query_time;
            end
            OP_INIT:
                present_reg <= 1'b1;
            OP_LOAD_LO:
                f_lo_reg <= frame_rd_reg;
            OP_CMP:
            begin
                if (pair_hit)
                begin
                    left_reg <= idx_reg;
                    hit_reg  <= 1'b1;
                    rem_reg  <= t_reg - f_lo_reg;
                    den_reg  <= frame_rd_reg - f_lo_reg;
                end
                else
                    f_lo_reg <= frame_rd_reg;
            end
            OP_CLAMP:
            begin
                left_reg <= idx_reg;
                hit_reg  <= 1'b0;
            end
            OP_LOAD_VAL:
                acc_reg <= value_rd_reg;
            OP_LOAD_DEF:
            begin
                acc_reg     <= default_value;
                left_reg    <= '0;
                hit_reg     <= 1'b0;
                present_reg <= 1'b0;
            end
            OP_DIV:
            begin
                rem_reg <= rem_next;
                q_reg   <= {q_reg[FRAC_W-2:0], div_bit};
            end
            OP_LOAD_V0:
                v0_reg <= value_rd_reg;
            OP_DIFF:
                diff_reg <= {value_rd_reg[VALUE_W-1], value_rd_reg} - {v0_reg[VALUE_W-1], v0_reg};
            OP_MUL:
                prod_reg <= prod_next;
            OP_BLEND:
                acc_reg <= blend_sum[VALUE_W-1:0];
            OP_SCALE:
                sprod_reg <= sprod_next;
            OP_EMIT:
            begin
                if (out_free)
                begin
                    out_value_reg   <= sat_value;
                    out_left_reg    <= SLOT_W'(left_reg);
                    out_hit_reg     <= hit_reg;
                    out_present_reg <= present_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign sample.valid         = out_valid_reg;
    assign sample.sample_value  = out_value_reg;
    assign sample.left_key      = out_left_reg;
    assign sample.bracketed     = out_hit_reg;
    assign sample.track_present = out_present_reg;

endmodule

// ===== bench/tb_keyframe_track_interpolator_core.sv =====
// self-checking testbench of the keyframe track interpolator core
module tb_keyframe_track_interpolator_core;
    import kti_pkg::*;

    localparam int          HALF_PERIOD    = 5;
    localparam int          RESET_CYCLES   = 4;
    localparam int          MAX_GAP        = 14;
    localparam int          SETTLE_CYCLES  = 240;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          ITEM_TARGET    = 1350;
    localparam int unsigned FRAME_MAX      = 32'h00FF_FFFF;
    localparam longint      GAIN_0788      = 51642;
    localparam longint      VALUE_HI       = 64'sd2147483647;
    localparam longint      VALUE_LO       = -64'sd2147483648;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic [SLOT_W-1:0]         left_key;
        logic                      bracketed;
        logic                      track_present;
    } sample_beat_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    kti_item_if   item_bus ();
    kti_sample_if sample_bus ();

    keyframe_track_interpolator_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_bus),
        .sample  (sample_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // mirror of the track and the registers
    logic [FRAME_W-1:0]        track_frame [MAX_KEYS];
    logic signed [VALUE_W-1:0] track_value [MAX_KEYS];
    logic [KEY_CNT_W-1:0]      cfg_key_count;
    logic signed [VALUE_W-1:0] cfg_default;

    sample_beat_t pending_samples [$];

    int fail_count;
    int items_sent;
    int writes_sent;
    int queries_sent;
    int reg_writes;
    int hit_count;
    int clamp_count;
    int empty_count;
    int idle_cycles;
    bit tx_no_gap;
    bit rx_no_stall;

    always #(HALF_PERIOD) clk = ~clk;

    function automatic logic signed [VALUE_W-1:0] scale_q16(input longint v);
        longint s;
        s = (v * GAIN_0788 + 32768) >>> 16;
        if (s > VALUE_HI)
            s = VALUE_HI;
        if (s < VALUE_LO)
            s = VALUE_LO;
        return s[VALUE_W-1:0];
    endfunction

    function automatic sample_beat_t interpolate_sample(input logic [FRAME_W-1:0] t);
        sample_beat_t      r;
        int                n;
        int                i;
        int                left;
        bit                hit;
        longint unsigned   span;
        longint unsigned   frac;
        longint            v0;
        longint            v1;
        longint            blended;
        n = (cfg_key_count > MAX_KEYS) ? MAX_KEYS : int'(cfg_key_count);
        hit = 1'b0;
        left = 0;
        r.track_present = (n != 0);
        if (n == 0)
        begin
            r.value = scale_q16(longint'(cfg_default));
            r.left_key = '0;
            r.bracketed = 1'b0;
            return r;
        end
        for (i = 0; i + 1 < n && !hit; i++)
        begin
            if (track_frame[i] <= t && t < track_frame[i+1])
            begin
                hit = 1'b1;
                left = i;
            end
        end
        if (hit)
        begin
            span = track_frame[left+1] - track_frame[left];
            frac = t - track_frame[left];
            frac = (frac << 16) / span;
            v0 = track_value[left];
            v1 = track_value[left+1];
            blended = v0 + (((v1 - v0) * signed'(frac)) >>> 16);
        end
        else
        begin
            left = n - 1;
            blended = track_value[left];
        end
        r.value = scale_q16(blended);
        r.left_key = left[SLOT_W-1:0];
        r.bracketed = hit;
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
            default: return $urandom;
        endcase
    endfunction

    // n is the effective key count
    function automatic logic [FRAME_W-1:0] random_time(input int n);
        int k;
        if (n == 0)
            return FRAME_W'($urandom);
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
            0: return FRAME_W'($urandom);
            1: return track_frame[k];
            2: return track_frame[k] - 1'b1;
            default: return FRAME_W'($urandom_range(track_frame[0], track_frame[n-1]));
        endcase
    endfunction

    task automatic send_beat(input logic cmd, input logic [SLOT_W-1:0] slot,
                             input logic [FRAME_W-1:0] frame,
                             input logic [VALUE_W-1:0] value,
                             input logic [FRAME_W-1:0] t);
        int           gap;
        sample_beat_t predicted;
        gap = tx_no_gap ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid      <= 1'b1;
        item_bus.command    <= cmd;
        item_bus.key_slot   <= slot;
        item_bus.key_frame  <= frame;
        item_bus.key_value  <= value;
        item_bus.query_time <= t;
        do @(posedge clk); while (!item_bus.ready);
        items_sent++;
        if (cmd == CMD_WRITE)
        begin
            track_frame[slot] = frame;
            track_value[slot] = value;
            writes_sent++;
        end
        else
        begin
            predicted = interpolate_sample(t);
            pending_samples.push_back(predicted);
            queries_sent++;
            if (!predicted.track_present)
                empty_count++;
            else if (predicted.bracketed)
                hit_count++;
            else
                clamp_count++;
        end
    endtask

    task automatic write_key(input logic [SLOT_W-1:0] slot, input logic [FRAME_W-1:0] frame,
                             input logic [VALUE_W-1:0] value);
        send_beat(CMD_WRITE, slot, frame, value, FRAME_W'($urandom));
    endtask

    task automatic query_track(input logic [FRAME_W-1:0] t);
        send_beat(CMD_QUERY, SLOT_W'($urandom), FRAME_W'($urandom), $urandom, t);
    endtask

    // hold the sender until every sample beat is back, then let a search finish
    task automatic wait_idle();
        item_bus.valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write a register, then read it back in the next transfer
    task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        logic [DATA_W-1:0] mask;
        mask = '1;
        if (addr == REG_KEY_COUNT)
            mask = {{(DATA_W-KEY_CNT_W){1'b0}}, {KEY_CNT_W{1'b1}}};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        reg_writes++;
        if (addr == REG_KEY_COUNT)
            cfg_key_count = data[KEY_CNT_W-1:0];
        else
            cfg_default = data;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if ((prdata & mask) !== (data & mask))
        begin
            fail_count++;
            $error("register at %0d: expected %h got %h", addr, data & mask, prdata & mask);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // ordered tracks rise or repeat a frame from key to key, the others are scattered
    task automatic load_track(input int count, input bit ordered);
        int unsigned step_cap;
        int unsigned frame;
        int          k;
        case ($urandom_range(0, 2))
            0: step_cap = 16;
            1: step_cap = 4096;
            default: step_cap = 32'h3_FFFF;
        endcase
        frame = $urandom_range(0, FRAME_MAX - count * step_cap);
        for (k = 0; k < count; k++)
        begin
            if (!ordered)
                frame = $urandom_range(0, FRAME_MAX);
            write_key(SLOT_W'(k), FRAME_W'(frame), random_value());
            frame += ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, step_cap);
        end
    endtask

    task automatic test_empty_track();
        logic [DATA_W-1:0] limit_values [4];
        limit_values[0] = 32'h7FFF_FFFF;
        limit_values[1] = 32'h8000_0000;
        limit_values[2] = 32'hFFFF_FFFF;
        limit_values[3] = 32'h0001_8000;
        // out of reset the track is empty and the default is zero
        query_track('0);
        query_track(FRAME_W'(FRAME_MAX));
        foreach (limit_values[k])
        begin
            wait_idle();
            write_register(REG_DEFAULT_VALUE, limit_values[k]);
            query_track(FRAME_W'($urandom));
        end
    endtask

    task automatic test_directed_keys();
        write_key(6'd0, 24'h00_0010, 32'h8000_0000);
        write_key(6'd1, 24'h00_0100, 32'h7FFF_FFFF);
        // same frame as key 1, so that pair never brackets
        write_key(6'd2, 24'h00_0100, 32'h0000_0000);
        write_key(6'd3, 24'hFF_FFFF, 32'h0001_0000);
        wait_idle();
        write_register(REG_KEY_COUNT, 32'd1);
        query_track(24'h00_0000);
        query_track(24'hFF_FFFF);
        wait_idle();
        write_register(REG_KEY_COUNT, 32'd2);
        query_track(24'h00_0080);
        query_track(24'h00_0100);
        wait_idle();
        write_register(REG_KEY_COUNT, 32'd4);
        query_track(24'h00_0000);
        query_track(24'h00_0010);
        query_track(24'h00_00FF);
        query_track(24'h00_0100);
        query_track(24'h80_0000);
        query_track(24'hFF_FFFE);
        query_track(24'hFF_FFFF);
    endtask

    task automatic test_full_track();
        logic [KEY_CNT_W-1:0] counts [3];
        int                   k;
        counts[0] = 7'd64;
        counts[1] = 7'd127;
        counts[2] = 7'd65;
        load_track(MAX_KEYS, 1'b1);
        wait_idle();
        foreach (counts[c])
        begin
            write_register(REG_KEY_COUNT, DATA_W'(counts[c]));
            query_track(track_frame[MAX_KEYS-1]);
            query_track(track_frame[MAX_KEYS-2]);
            for (k = 0; k < 4; k++)
                query_track(random_time(MAX_KEYS));
            wait_idle();
        end
    endtask

    task automatic test_random_tracks();
        int n_keys;
        int eff;
        int phase_len;
        int k;
        bit ordered;
        while (items_sent < ITEM_TARGET)
        begin
            tx_no_gap   = ($urandom_range(0, 3) == 0);
            rx_no_stall = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 15))
                0: n_keys = 0;
                1: n_keys = $urandom_range(MAX_KEYS + 1, 127);
                2, 3: n_keys = $urandom_range(9, MAX_KEYS);
                default: n_keys = $urandom_range(1, 8);
            endcase
            eff = (n_keys > MAX_KEYS) ? MAX_KEYS : n_keys;
            ordered = ($urandom_range(0, 4) != 0);
            load_track(eff, ordered);
            wait_idle();
            write_register(REG_KEY_COUNT, DATA_W'(n_keys));
            if ($urandom_range(0, 3) == 0)
                write_register(REG_DEFAULT_VALUE, random_value());
            phase_len = $urandom_range(4, 24);
            for (k = 0; k < phase_len; k++)
            begin
                // an occasional key rewrite in the middle, which may break the order
                if ($urandom_range(0, 9) == 0)
                    write_key(SLOT_W'($urandom_range(0, MAX_KEYS - 1)), FRAME_W'($urandom),
                              random_value());
                else
                    query_track(random_time(eff));
            end
            wait_idle();
        end
        tx_no_gap   = 1'b0;
        rx_no_stall = 1'b0;
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        item_bus.valid      <= 1'b0;
        item_bus.command    <= CMD_WRITE;
        item_bus.key_slot   <= '0;
        item_bus.key_frame  <= '0;
        item_bus.key_value  <= '0;
        item_bus.query_time <= '0;
        cfg_key_count = '0;
        cfg_default   = '0;
        foreach (track_frame[k])
        begin
            track_frame[k] = '0;
            track_value[k] = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_track();
        test_directed_keys();
        test_full_track();
        test_random_tracks();
        wait_idle();
        $display("covered %0d key writes, %0d queries and %0d register writes",
                 writes_sent, queries_sent, reg_writes);
        $display("queries: %0d bracketed, %0d held at the last key, %0d on an empty track",
                 hit_count, clamp_count, empty_count);
        if (fail_count == 0)
            $display("keyframe_track_interpolator_core verification clean");
        else
            $display("keyframe_track_interpolator_core verification failed");
        $finish;
    end

    // result side: a random stall before each beat, none while rx_no_stall is set
    initial
    begin
        int stall;
        sample_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = rx_no_stall ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                sample_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            sample_bus.ready <= 1'b1;
            do @(posedge clk); while (!sample_bus.valid);
        end
    end

    always @(posedge clk)
    begin
        sample_beat_t want;
        if (rst_n && sample_bus.valid && sample_bus.ready)
        begin
            if (pending_samples.size() == 0)
            begin
                fail_count++;
                $error("sample beat with no query outstanding");
            end
            else
            begin
                want = pending_samples.pop_front();
                if (sample_bus.sample_value !== want.value)
                begin
                    fail_count++;
                    $error("sample_value: expected %0d got %0d", want.value,
                           sample_bus.sample_value);
                end
                if (sample_bus.left_key !== want.left_key)
                begin
                    fail_count++;
                    $error("left_key: expected %0d got %0d", want.left_key, sample_bus.left_key);
                end
                if (sample_bus.bracketed !== want.bracketed)
                begin
                    fail_count++;
                    $error("bracketed: expected %0d got %0d", want.bracketed,
                           sample_bus.bracketed);
                end
                if (sample_bus.track_present !== want.track_present)
                begin
                    fail_count++;
                    $error("track_present: expected %0d got %0d", want.track_present,
                           sample_bus.track_present);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_bus.valid && item_bus.ready) || (sample_bus.valid && sample_bus.ready)
            || (psel && penable))
            idle_cycles = 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("keyframe_track_interpolator_core verification failed");
            $finish;
        end
        else
            idle_cycles = idle_cycles + 1;
    end

endmodule
